// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sve_pkg.sv =====
// ----------------------------------------------------------------------------
// sve_pkg
// types and constants for the signed variable-length integer encoder
// ----------------------------------------------------------------------------
package sve_pkg;

  localparam int VAL_W       = 64;
  localparam int BYTE_W      = 8;
  localparam int OFS_W       = 48;
  localparam int NB_W        = 4;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [NB_W-1:0] MAX_PAYLOAD = 4'd8;

  // single-byte range
  localparam logic signed [VAL_W-1:0] SMALL_LO = -64'sd32;
  localparam logic signed [VAL_W-1:0] SMALL_HI = 64'sd127;

  // short forms: top byte ranges and prefix offsets
  localparam logic signed [BYTE_W-1:0] F1_LO  = -8'sd20;
  localparam logic signed [BYTE_W-1:0] F1_HI  = 8'sd19;
  localparam logic signed [BYTE_W-1:0] F1_OFS = 8'sd52;
  localparam logic signed [BYTE_W-1:0] F2_LO  = -8'sd16;
  localparam logic signed [BYTE_W-1:0] F2_HI  = 8'sd15;
  localparam logic signed [BYTE_W-1:0] F2_OFS = 8'sd88;
  localparam logic signed [BYTE_W-1:0] F3_LO  = -8'sd8;
  localparam logic signed [BYTE_W-1:0] F3_HI  = 8'sd7;
  localparam logic signed [BYTE_W-1:0] F3_OFS = 8'sd112;

  // len - 129 taken modulo 256
  localparam logic [BYTE_W-1:0] LEN_BIAS = 8'd127;

  // one classified word: prefix byte, then nbytes payload bytes of value
  // nbytes of zero means the prefix is the whole encoding
  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [BYTE_W-1:0] prefix;
    logic [NB_W-1:0]   nbytes;
  } desc_t;

endpackage

// ===== sv/sve_front.sv =====
// ----------------------------------------------------------------------------
// sve_front
// accepts input words, finds the encoding form and registers a descriptor
// ----------------------------------------------------------------------------
module sve_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [sve_pkg::VAL_W-1:0]    in_value,
  output logic                                desc_vld,
  output sve_pkg::desc_t                      desc,
  input  logic                                desc_rdy
);
  import sve_pkg::*;

  logic  vld_r, vld_nxt;
  desc_t desc_r, desc_nxt;
  logic  accept;

  logic [VAL_W-1:0]         un;
  logic [2:0]               hb;
  logic [NB_W-1:0]          len;
  logic [5:0]               sh;
  logic signed [BYTE_W-1:0] top, sgn, fb1, fb2, fb3;
  logic                     one_byte, ok1, ok2, ok3;

  assign accept   = in_push && !in_full;
  assign in_full  = vld_r && !desc_rdy;
  assign desc_vld = vld_r;
  assign desc     = desc_r;

  always_comb begin
    un = in_value[VAL_W-1] ? ~in_value : in_value;
    hb = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (|un[8*k +: 8]) begin
        hb = 3'(k);
      end
    end
    // one more byte when the top magnitude bit lands on a sign position
    len = {1'b0, hb} + 4'd1 + {3'b000, un[{hb, 3'b111}]};
    sh  = {3'(len - 4'd1), 3'b000};
    top = in_value[sh +: 8];
    sgn = {BYTE_W{in_value[VAL_W-1]}};

    one_byte = (in_value <= SMALL_HI) && (in_value >= SMALL_LO);

    fb1 = (len == 4'd1) ? sgn : top;
    ok1 = (len <= 4'd2) && (fb1 >= F1_LO) && (fb1 <= F1_HI);
    fb2 = ((len <= 4'd2) && !ok1) ? sgn : fb1;
    ok2 = !ok1 && (len <= 4'd3) && (fb2 >= F2_LO) && (fb2 <= F2_HI);
    fb3 = (!ok1 && (len <= 4'd3) && !ok2) ? sgn : fb2;
    ok3 = !ok1 && !ok2 && (len <= 4'd4) && (fb3 >= F3_LO) && (fb3 <= F3_HI);

    desc_nxt.value = in_value;
    priority if (one_byte) begin
      desc_nxt.prefix = in_value[BYTE_W-1:0];
      desc_nxt.nbytes = 4'd0;
    end else if (ok1) begin
      desc_nxt.prefix = fb1 - F1_OFS;
      desc_nxt.nbytes = 4'd1;
    end else if (ok2) begin
      desc_nxt.prefix = fb2 - F2_OFS;
      desc_nxt.nbytes = 4'd2;
    end else if (ok3) begin
      desc_nxt.prefix = fb3 - F3_OFS;
      desc_nxt.nbytes = 4'd3;
    end else begin
      desc_nxt.prefix = {4'b0000, len} + LEN_BIAS;
      desc_nxt.nbytes = len;
    end
  end

  always_comb begin
    priority if (accept) begin
      vld_nxt = 1'b1;
    end else if (desc_rdy) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_nxt;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_front_nbytes, vld_r, desc_r.nbytes <= MAX_PAYLOAD, "payload length out of range")

endmodule

// ===== sv/sve_fifo.sv =====
// ----------------------------------------------------------------------------
// sve_fifo
// short descriptor queue between front and back
// ----------------------------------------------------------------------------
module sve_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_fifo_cnt, cnt_r <= CW'(DEPTH), "queue count beyond depth")
  `ASSERT_NEXT(a_fifo_grow, push_ok && !pop_ok, cnt_r == $past(cnt_r) + CW'(1), "queue count slip")

endmodule

// ===== sv/sve_back.sv =====
// ----------------------------------------------------------------------------
// sve_back
// serializes prefix and payload bytes into the output register
// ----------------------------------------------------------------------------
module sve_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fifo_empty,
  input  sve_pkg::desc_t                fifo_dout,
  output logic                          fifo_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [sve_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last,
  output logic [sve_pkg::OFS_W-1:0]     out_offset_after
);
  import sve_pkg::*;

  logic              busy_r, busy_nxt;
  logic [NB_W-1:0]   rem_r, rem_nxt;
  logic [VAL_W-1:0]  val_r;
  logic              out_vld_r, out_vld_nxt;
  logic [BYTE_W-1:0] out_byte_r, byte_nxt;
  logic              out_last_r, last_nxt;
  logic [OFS_W-1:0]  offset_r;
  logic              adv, emit, take;
  logic [2:0]        idx;

  assign adv              = !out_vld_r || out_pop;
  assign idx              = 3'(rem_r - 4'd1);
  assign fifo_pop         = take;
  assign out_empty        = !out_vld_r;
  assign out_byte         = out_byte_r;
  assign out_last         = out_last_r;
  assign out_offset_after = offset_r;

  always_comb begin
    emit     = 1'b0;
    take     = 1'b0;
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    byte_nxt = out_byte_r;
    last_nxt = out_last_r;
    if (adv) begin
      if (busy_r) begin
        emit     = 1'b1;
        byte_nxt = val_r[{idx, 3'b000} +: 8];
        last_nxt = (rem_r == 4'd1);
        rem_nxt  = rem_r - 4'd1;
        busy_nxt = (rem_r != 4'd1);
      end else if (!fifo_empty) begin
        emit     = 1'b1;
        take     = 1'b1;
        byte_nxt = fifo_dout.prefix;
        last_nxt = (fifo_dout.nbytes == 4'd0);
        rem_nxt  = fifo_dout.nbytes;
        busy_nxt = (fifo_dout.nbytes != 4'd0);
      end
    end
    out_vld_nxt = emit ? 1'b1 : (out_pop ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rem_r     <= '0;
      out_vld_r <= 1'b0;
      offset_r  <= '0;
    end else begin
      busy_r    <= busy_nxt;
      rem_r     <= rem_nxt;
      out_vld_r <= out_vld_nxt;
      if (emit) begin
        offset_r <= offset_r + OFS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      val_r <= fifo_dout.value;
    end
    if (emit) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last_nxt;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_back_rem, busy_r, (rem_r != 4'd0) && (rem_r <= MAX_PAYLOAD), "bad byte count")
  `ASSERT_NEXT(a_back_last, adv && busy_r && (rem_r == 4'd1), out_last_r && !busy_r, "last flag missed")

endmodule

// ===== sv/signed_vlong_encoder_unit.sv =====
// path: front descriptor register, queue, output register; a value is 1 to 9 bytes
// throughput: the back serializer emits one byte per cycle unless out_pop stalls it
// the front takes one value per cycle unless in_full; bytes are prefix then payload
// reset: synchronous active-low rst_n empties front, queue and output, clears the offset
// ----------------------------------------------------------------------------
// signed_vlong_encoder_unit
// zero-compressed variable-length encoder for signed 64-bit words
// ----------------------------------------------------------------------------
module signed_vlong_encoder_unit #(
  parameter int FIFO_DEPTH = sve_pkg::FIFO_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic signed [sve_pkg::VAL_W-1:0]   in_value,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [sve_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_last,
  output logic [sve_pkg::OFS_W-1:0]          out_offset_after
);
  import sve_pkg::*;

  desc_t front_desc, fifo_dout;
  logic  front_vld, fifo_full, fifo_empty, fifo_pop;

  sve_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .desc_vld (front_vld),
    .desc     (front_desc),
    .desc_rdy (!fifo_full)
  );

  sve_fifo #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_vld),
    .full  (fifo_full),
    .din   (front_desc),
    .pop   (fifo_pop),
    .empty (fifo_empty),
    .dout  (fifo_dout)
  );

  sve_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_empty       (fifo_empty),
    .fifo_dout        (fifo_dout),
    .fifo_pop         (fifo_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_offset_after (out_offset_after)
  );

endmodule
